@@ rtl/crc_pkg.sv @@
// Shared types and constants for the circle raster canvas.
package crc_pkg;

  // Operation codes carried by the operation field
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Register indexes on the APB port (byte address = 4 * index)
  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG_CHAR       = 2'd2;

  localparam int PADDR_W = 4;

  localparam logic [8:0] RST_CANVAS_WIDTH  = 9'd256;
  localparam logic [8:0] RST_CANVAS_HEIGHT = 9'd256;
  localparam logic [7:0] RST_BG_CHAR       = 8'd32;

  // Q.8 fixed point: one pixel is 256, one pixel squared is 65536
  localparam int R_ONE     = 256;
  localparam int SQ_ONE    = 65536;
  localparam int PIX_SHIFT = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_SCAN,
    ST_RADDR,
    ST_RMEM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic idle;
    logic load;
    logic setup_step;
    logic scan_init;
    logic scan_step;
    logic addr_calc;
    logic mem_rd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       radius_zero;
    logic       empty;
    logic       read_out;
    logic       setup_last;
    logic       scan_last;
  } status_t;

endpackage

@@ rtl/crc_ctrl.sv @@
// Sequencer for the circle raster canvas: decode, square setup, scan, read, result.
module crc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_free_i,
  input  crc_pkg::status_t status_i,
  output crc_pkg::cmd_t    cmd_o
);

  crc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      crc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = crc_pkg::ST_DECODE;
      end
      crc_pkg::ST_DECODE: begin
        case (status_i.op)
          crc_pkg::OP_CLEAR: begin
            state_d = status_i.empty ? crc_pkg::ST_DONE : crc_pkg::ST_SCAN;
          end
          crc_pkg::OP_DRAW: begin
            state_d = (status_i.radius_zero || status_i.empty) ?
                      crc_pkg::ST_DONE : crc_pkg::ST_SETUP;
          end
          crc_pkg::OP_READ: begin
            state_d = status_i.read_out ? crc_pkg::ST_DONE : crc_pkg::ST_RADDR;
          end
          default: state_d = crc_pkg::ST_DONE;
        endcase
      end
      crc_pkg::ST_SETUP: begin
        if (status_i.setup_last) state_d = crc_pkg::ST_SCAN;
      end
      crc_pkg::ST_SCAN: begin
        if (status_i.scan_last) state_d = crc_pkg::ST_DONE;
      end
      crc_pkg::ST_RADDR: state_d = crc_pkg::ST_RMEM;
      crc_pkg::ST_RMEM:  state_d = crc_pkg::ST_DONE;
      crc_pkg::ST_DONE: begin
        if (out_free_i) state_d = crc_pkg::ST_IDLE;
      end
      default: state_d = crc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      crc_pkg::ST_IDLE: begin
        cmd_o.idle = 1'b1;
        cmd_o.load = in_valid_i;
      end
      crc_pkg::ST_DECODE: begin
        cmd_o.scan_init = (status_i.op == crc_pkg::OP_CLEAR) && !status_i.empty;
      end
      crc_pkg::ST_SETUP: begin
        cmd_o.setup_step = 1'b1;
        cmd_o.scan_init  = status_i.setup_last;
      end
      crc_pkg::ST_SCAN:  cmd_o.scan_step = 1'b1;
      crc_pkg::ST_RADDR: cmd_o.addr_calc = 1'b1;
      crc_pkg::ST_RMEM:  cmd_o.mem_rd = 1'b1;
      crc_pkg::ST_DONE:  cmd_o.res_load = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/crc_datapath.sv @@
// Datapath of the circle raster canvas: item registers, squares, raster scan, frame store.
module crc_datapath #(
  parameter  int MAX_SIDE = 256,
  localparam int SW = $clog2(MAX_SIDE + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crc_pkg::cmd_t    cmd_i,
  output crc_pkg::status_t status_o,
  input  logic [1:0]       operation_i,
  input  logic [19:0]      center_x_i,
  input  logic [19:0]      center_y_i,
  input  logic [19:0]      radius_i,
  input  logic             filled_i,
  input  logic [7:0]       paint_char_i,
  input  logic [7:0]       cell_x_i,
  input  logic [7:0]       cell_y_i,
  input  logic [SW-1:0]    w_eff_i,
  input  logic [SW-1:0]    h_eff_i,
  input  logic [7:0]       bg_char_i,
  output logic [7:0]       res_cell_o,
  output logic             res_err_o
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // offset 256*x - cx, signed
  localparam int EW    = $clog2(524288 + crc_pkg::R_ONE * MAX_SIDE + 1) + 1;
  localparam int DW    = 2 * EW + 1;
  localparam int RW    = (SW > 8) ? SW : 8;

  localparam logic signed [EW-1:0] EX_STEP = EW'(crc_pkg::R_ONE);
  localparam logic signed [DW-1:0] SQ_STEP = DW'(crc_pkg::SQ_ONE);

  localparam logic [1:0] SQ_CX    = 2'd0;
  localparam logic [1:0] SQ_CY    = 2'd1;
  localparam logic [1:0] SQ_R     = 2'd2;
  localparam logic [1:0] SQ_INNER = 2'd3;

  // item registers
  logic [1:0]         op_q;
  logic signed [19:0] cx_q, cy_q;
  logic [19:0]        radius_q;
  logic               filled_q;
  logic [7:0]         paint_q;
  logic [7:0]         cell_x_q, cell_y_q;

  // squares
  logic signed [DW-1:0] cx2_q, cy2_q, r2_q, inner2_q;
  logic [1:0]           setup_cnt_q;
  logic signed [20:0]   mul_a;
  logic signed [41:0]   mul_p;

  // scan state
  logic [SW-1:0]        x_q, y_q;
  logic [AW-1:0]        addr_q;
  logic signed [EW-1:0] ex_q, ey_q;
  logic signed [DW-1:0] ex2_q, ey2_q;
  logic                 last_x, last_y;
  logic signed [DW-1:0] d_sum;
  logic                 thin, in_disc, border, hit;
  logic                 mem_we;
  logic [7:0]           mem_wdata;

  // read path
  logic [AW-1:0] rd_addr_q;
  logic [7:0]    rd_data_q;
  logic [7:0]    mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      cx_q     <= center_x_i;
      cy_q     <= center_y_i;
      radius_q <= radius_i;
      filled_q <= filled_i;
      paint_q  <= paint_char_i;
      cell_x_q <= cell_x_i;
      cell_y_q <= cell_y_i;
    end
  end

  assign thin = (radius_q[19:8] == '0);

  always_comb begin
    case (setup_cnt_q)
      SQ_CX:    mul_a = {cx_q[19], cx_q};
      SQ_CY:    mul_a = {cy_q[19], cy_q};
      SQ_R:     mul_a = {1'b0, radius_q};
      SQ_INNER: mul_a = thin ? '0 : {1'b0, radius_q - 20'(crc_pkg::R_ONE)};
      default:  mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_step) begin
      case (setup_cnt_q)
        SQ_CX:    cx2_q    <= DW'(mul_p);
        SQ_CY:    cy2_q    <= DW'(mul_p);
        SQ_R:     r2_q     <= DW'(mul_p);
        SQ_INNER: inner2_q <= DW'(mul_p);
        default:  r2_q     <= r2_q;
      endcase
    end
  end

  assign last_x = (x_q == w_eff_i - SW'(1));
  assign last_y = (y_q == h_eff_i - SW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_cnt_q <= '0;
      x_q         <= '0;
      y_q         <= '0;
      addr_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        setup_cnt_q <= '0;
      end else if (cmd_i.setup_step) begin
        setup_cnt_q <= setup_cnt_q + 2'd1;
      end
      if (cmd_i.scan_init) begin
        x_q    <= '0;
        y_q    <= '0;
        addr_q <= '0;
      end else if (cmd_i.scan_step) begin
        addr_q <= addr_q + AW'(1);
        if (last_x) begin
          x_q <= '0;
          y_q <= y_q + SW'(1);
        end else begin
          x_q <= x_q + SW'(1);
        end
      end
    end
  end

  // (e + 256)^2 = e^2 + 512 e + 65536, so the squares follow the scan with adds
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      ex_q  <= -EW'(cx_q);
      ey_q  <= -EW'(cy_q);
      ex2_q <= cx2_q;
      ey2_q <= cy2_q;
    end else if (cmd_i.scan_step) begin
      if (last_x) begin
        ex_q  <= -EW'(cx_q);
        ex2_q <= cx2_q;
        ey_q  <= ey_q + EX_STEP;
        ey2_q <= ey2_q + (DW'(ey_q) <<< crc_pkg::PIX_SHIFT) + SQ_STEP;
      end else begin
        ex_q  <= ex_q + EX_STEP;
        ex2_q <= ex2_q + (DW'(ex_q) <<< crc_pkg::PIX_SHIFT) + SQ_STEP;
      end
    end
  end

  assign d_sum   = ex2_q + ey2_q;
  assign in_disc = (d_sum <= r2_q);
  assign border  = thin || (d_sum > inner2_q);
  assign hit     = in_disc && (filled_q || border);

  assign mem_we    = cmd_i.scan_step && ((op_q == crc_pkg::OP_CLEAR) || hit);
  assign mem_wdata = (op_q == crc_pkg::OP_CLEAR) ? bg_char_i : paint_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_calc) begin
      rd_addr_q <= AW'(AW'(cell_y_q) * AW'(w_eff_i) + AW'(cell_x_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  assign status_o.op          = op_q;
  assign status_o.radius_zero = (radius_q == '0);
  assign status_o.empty       = (w_eff_i == '0) || (h_eff_i == '0);
  assign status_o.read_out    = (RW'(cell_x_q) >= RW'(w_eff_i)) ||
                                (RW'(cell_y_q) >= RW'(h_eff_i));
  assign status_o.setup_last  = (setup_cnt_q == SQ_INNER);
  assign status_o.scan_last   = last_x && last_y;

  assign res_cell_o = ((op_q == crc_pkg::OP_READ) && !status_o.read_out) ? rd_data_q : 8'd0;
  assign res_err_o  = ((op_q == crc_pkg::OP_DRAW) && status_o.radius_zero) ||
                      ((op_q == crc_pkg::OP_READ) && status_o.read_out);

endmodule

@@ rtl/circle_raster_canvas_top.sv @@
// Top level of the circle raster canvas: APB registers, sequencer, datapath, result register.
//
// Character canvas of canvas_width x canvas_height cells (each clamped to
// MAX_SIDE) kept in a single-port-write, registered-read frame store, cell
// (x, y) at address y * width + x. One word in gives one word out. The block
// works on one word at a time; a finished result sits in the output register
// while the next word is already taken. From acceptance to the result register,
// clear runs the raster scan; draw first squares center and radius on one shared
// 21x21 multiplier, then runs the scan with one frame store write slot per cell;
// read computes the address, then reads the frame store; a draw with zero radius,
// an out-of-range read, an empty canvas or an unused code goes straight to it.
// The raster scan writes one cell per clock through the frame store's single
// write port, so width * height sets the rate of clear and draw. The distance
// test is exact: squared offsets are carried incrementally along the scan
// ((e + 256)^2 = e^2 + 512e + 65536) and compared against r^2 and (r - 1)^2.
// The frame store has no reset; read a cell only after a clear or draw has
// written it. Registers: canvas_width at 0x0, canvas_height at 0x4,
// background_char at 0x8; write them only while the block is idle.
module circle_raster_canvas_top #(
  parameter int MAX_SIDE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [19:0] center_x_i,
  input  logic [19:0] center_y_i,
  input  logic [19:0] radius_i,
  input  logic        filled_i,
  input  logic [7:0]  paint_char_i,
  input  logic [7:0]  cell_x_i,
  input  logic [7:0]  cell_y_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cell_char_o,
  output logic        error_o,
  // APB
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = (SW > 9) ? SW : 9;

  logic [8:0]  cfg_w_q, cfg_h_q;
  logic [7:0]  cfg_bg_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic [SW-1:0] w_eff, h_eff;

  crc_pkg::cmd_t    cmd;
  crc_pkg::status_t status;

  logic       out_valid_q;
  logic [7:0] cell_char_q;
  logic       error_q;
  logic       out_free;
  logic [7:0] res_cell;
  logic       res_err;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= crc_pkg::RST_CANVAS_WIDTH;
      cfg_h_q  <= crc_pkg::RST_CANVAS_HEIGHT;
      cfg_bg_q <= crc_pkg::RST_BG_CHAR;
    end else if (cfg_wr) begin
      case (cfg_idx)
        crc_pkg::REG_CANVAS_WIDTH:  cfg_w_q  <= pwdata[8:0];
        crc_pkg::REG_CANVAS_HEIGHT: cfg_h_q  <= pwdata[8:0];
        crc_pkg::REG_BG_CHAR:       cfg_bg_q <= pwdata[7:0];
        default:                    cfg_bg_q <= cfg_bg_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      crc_pkg::REG_CANVAS_WIDTH:  prdata = 32'(cfg_w_q);
      crc_pkg::REG_CANVAS_HEIGHT: prdata = 32'(cfg_h_q);
      crc_pkg::REG_BG_CHAR:       prdata = 32'(cfg_bg_q);
      default:                    prdata = '0;
    endcase
  end

  // Sizes above MAX_SIDE saturate
  assign w_eff = (CMPW'(cfg_w_q) > CMPW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg_w_q);
  assign h_eff = (CMPW'(cfg_h_q) > CMPW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg_h_q);

  assign in_stall_o = !cmd.idle;
  // Result register frees up in the same cycle its word is taken
  assign out_free   = !out_valid_q || !out_stall_i;

  crc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crc_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .operation_i  (operation_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .filled_i     (filled_i),
    .paint_char_i (paint_char_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .w_eff_i      (w_eff),
    .h_eff_i      (h_eff),
    .bg_char_i    (cfg_bg_q),
    .res_cell_o   (res_cell),
    .res_err_o    (res_err)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.res_load) begin
      cell_char_q <= res_cell;
      error_q     <= res_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_char_o = cell_char_q;
  assign error_o     = error_q;

  // A word accepted on the input keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accept");

  // The result register is never overwritten while a word waits in it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // The scan stops right after the last canvas cell
  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_step && status.scan_last) |=> !cmd.scan_step)
    else $error("scan ran past the last cell");

  // An error result never carries a cell byte
  a_err_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (cell_char_o == 8'd0))
    else $error("error result with nonzero cell byte");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for circle_raster_canvas_top: directed and random words checked
// against a local model.
module tb_top;

  localparam int          MAX_SIDE    = 256;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          TAIL_CYCLES = 16;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_WORDS = 8;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] center_x;
    logic [19:0] center_y;
    logic [19:0] radius;
    logic        filled;
    logic [7:0]  paint_char;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
  } canvas_cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       error;
  } cell_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [19:0] center_x_i;
  logic [19:0] center_y_i;
  logic [19:0] radius_i;
  logic        filled_i;
  logic [7:0]  paint_char_i;
  logic [7:0]  cell_x_i;
  logic [7:0]  cell_y_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  cell_char_o;
  logic        error_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [crc_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  circle_raster_canvas_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of canvas state and registers
  logic [7:0] frame_model [MAX_SIDE*MAX_SIDE];
  logic [8:0] model_w  = crc_pkg::RST_CANVAS_WIDTH;
  logic [8:0] model_h  = crc_pkg::RST_CANVAS_HEIGHT;
  logic [7:0] model_bg = crc_pkg::RST_BG_CHAR;

  // Words waiting to be sent, their predicted replies, and replies owed by the block
  canvas_cmd_t cmd_q[$];
  cell_reply_t pending_reply_q[$];
  cell_reply_t reply_q[$];
  cell_reply_t held_reply;
  cell_reply_t want;
  canvas_cmd_t next_cmd;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          fail_count     = 0;
  int unsigned cycle_count    = 0;

  function automatic cell_reply_t predict_word(input canvas_cmd_t c);
    cell_reply_t rep;
    int unsigned w, h, x, y, n;
    longint      cx, cy, r, r2, inner2, dx, dy, dy2, d2;
    bit          thin;
    rep = '0;
    w = (model_w > MAX_SIDE) ? MAX_SIDE : model_w;
    h = (model_h > MAX_SIDE) ? MAX_SIDE : model_h;
    case (c.op)
      crc_pkg::OP_CLEAR: begin
        n = w * h;
        for (x = 0; x < n; x++) frame_model[x] = model_bg;
      end
      crc_pkg::OP_DRAW: begin
        if (c.radius == '0) begin
          rep.error = 1'b1;
        end else begin
          cx     = longint'($signed(c.center_x));
          cy     = longint'($signed(c.center_y));
          r      = longint'(c.radius);
          r2     = r * r;
          thin   = (r < crc_pkg::R_ONE);
          inner2 = thin ? 64'sd0 : (r - crc_pkg::R_ONE) * (r - crc_pkg::R_ONE);
          for (y = 0; y < h; y++) begin
            dy  = longint'(y) * crc_pkg::R_ONE - cy;
            dy2 = dy * dy;
            for (x = 0; x < w; x++) begin
              dx = longint'(x) * crc_pkg::R_ONE - cx;
              d2 = dy2 + dx * dx;
              // inside, and either a disc or on the ring
              if (d2 <= r2 && (c.filled || thin || d2 > inner2))
                frame_model[y*w + x] = c.paint_char;
            end
          end
        end
      end
      crc_pkg::OP_READ: begin
        if (c.cell_x >= w || c.cell_y >= h) rep.error = 1'b1;
        else rep.cell_char = frame_model[c.cell_y*w + c.cell_x];
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic canvas_cmd_t cmd_word(input logic [1:0] op, input logic [19:0] cx,
                                           input logic [19:0] cy, input logic [19:0] r,
                                           input logic fill, input logic [7:0] pc,
                                           input logic [7:0] x, input logic [7:0] y);
    canvas_cmd_t c;
    c = '{op, cx, cy, r, fill, pc, x, y};
    return c;
  endfunction

  task automatic push_cmd(input canvas_cmd_t c);
    cmd_q.push_back(c);
    pending_reply_q.push_back(predict_word(c));
  endtask

  // Block is idle once nothing is queued, nothing offered and no reply owed
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || reply_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      crc_pkg::REG_CANVAS_WIDTH:  model_w  = val[8:0];
      crc_pkg::REG_CANVAS_HEIGHT: model_h  = val[8:0];
      crc_pkg::REG_BG_CHAR:       model_bg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_canvas(input int w, input int h, input int bg);
    wait_drained();
    write_reg(crc_pkg::REG_CANVAS_WIDTH, 32'(w));
    write_reg(crc_pkg::REG_CANVAS_HEIGHT, 32'(h));
    write_reg(crc_pkg::REG_BG_CHAR, 32'(bg));
    @(negedge clk_i);
  endtask

  // Driver: offers the next queued word when the channel is free
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) reply_q.push_back(held_reply);
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd     = cmd_q.pop_front();
          held_reply   <= pending_reply_q.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= next_cmd.op;
          center_x_i   <= next_cmd.center_x;
          center_y_i   <= next_cmd.center_y;
          radius_i     <= next_cmd.radius;
          filled_i     <= next_cmd.filled;
          paint_char_i <= next_cmd.paint_char;
          cell_x_i     <= next_cmd.cell_x;
          cell_y_i     <= next_cmd.cell_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest owed reply
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result word, cell_char %02h error %b",
                   $time, cell_char_o, error_o);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (cell_char_o !== want.cell_char) begin
            $display("%0t: cell_char mismatch, expected %02h, actual %02h",
                     $time, want.cell_char, cell_char_o);
            fail_count++;
          end
          if (error_o !== want.error) begin
            $display("%0t: error mismatch, expected %b, actual %b",
                     $time, want.error, error_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    canvas_cmd_t c;
    int          p, i, w, h, pick;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = '0;
    center_x_i   = '0;
    center_y_i   = '0;
    radius_i     = '0;
    filled_i     = 1'b0;
    paint_char_i = '0;
    cell_x_i     = '0;
    cell_y_i     = '0;
    out_stall_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full 256x256 canvas from reset: clear, outline, corners, ring and hollow centre
    push_cmd(cmd_word(crc_pkg::OP_CLEAR, '0, '0, '0, 1'b0, '0, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, 20'(128*256), 20'(128*256), 20'(100*256), 1'b0,
                      8'h43, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd0, 8'd0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd255, 8'd255));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd228, 8'd128));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd128, 8'd128));

    // Small canvas: zero radius, extreme centre and radius, sub-pixel radius, unused code
    set_canvas(8, 6, 0);
    push_cmd(cmd_word(crc_pkg::OP_CLEAR, '0, '0, '0, 1'b0, '0, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, 20'd512, 20'd512, 20'd0, 1'b1, 8'h11, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, 20'h80000, 20'h7FFFF, 20'hFFFFF, 1'b1, 8'hFF, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, 20'(3*256), 20'(2*256), 20'h80, 1'b0, 8'h63, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, 20'(5*256+128), 20'(3*256+64), 20'd512, 1'b1,
                      8'h2A, '0, '0));
    push_cmd(cmd_word(OP_UNUSED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 8'hFF, 8'hFF,
                      8'hFF));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd3, 8'd2));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd5, 8'd3));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd0, 8'd0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd7, 8'd5));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd8, 8'd0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd0, 8'd6));

    // Empty canvas: nothing written, every read errs
    set_canvas(0, 5, 8'h55);
    push_cmd(cmd_word(crc_pkg::OP_CLEAR, '0, '0, '0, 1'b0, '0, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, '0, '0, 20'd256, 1'b1, 8'h43, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd0, 8'd0));

    // Oversized width saturates to MAX_SIDE, single row
    set_canvas(511, 1, 255);
    push_cmd(cmd_word(crc_pkg::OP_CLEAR, '0, '0, '0, 1'b0, '0, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_DRAW, 20'(100*256), '0, 20'(10*256), 1'b0, 8'h43, '0, '0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd255, 8'd0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd110, 8'd0));
    push_cmd(cmd_word(crc_pkg::OP_READ, '0, '0, '0, 1'b0, '0, 8'd0, 8'd1));

    // Random phases on small canvases, cycling through the idling modes
    for (p = 0; p < RAND_PHASES; p++) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      set_canvas(w, h, $urandom_range(0, 255));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // every in-range cell gets written before any read
      push_cmd(cmd_word(crc_pkg::OP_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom), 1'b0,
                        8'($urandom), 8'($urandom), 8'($urandom)));
      for (i = 0; i < PHASE_WORDS; i++) begin
        // sender holds off until the block has answered everything
        if (p == 5 && i == PHASE_WORDS / 2) wait_drained();
        c.center_x   = 20'($urandom);
        c.center_y   = 20'($urandom);
        c.radius     = 20'($urandom);
        c.filled     = 1'($urandom);
        c.paint_char = 8'($urandom);
        c.cell_x     = 8'($urandom);
        c.cell_y     = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) c.op = crc_pkg::OP_CLEAR;
        else if (pick < 50) c.op = crc_pkg::OP_DRAW;
        else if (pick < 94) c.op = crc_pkg::OP_READ;
        else c.op = OP_UNUSED;
        if (c.op == crc_pkg::OP_DRAW) begin
          if ($urandom_range(99) < 85) begin
            c.center_x = 20'($urandom_range(0, w*256 + 256) - 128);
            c.center_y = 20'($urandom_range(0, h*256 + 256) - 128);
          end
          pick = $urandom_range(99);
          if (pick < 5) c.radius = '0;
          else if (pick < 20) c.radius = 20'($urandom_range(1, 255));
          else if (pick < 90) c.radius = 20'($urandom_range(256, 256*14));
        end else if (c.op == crc_pkg::OP_READ && $urandom_range(99) < 75) begin
          c.cell_x = 8'($urandom_range(0, w - 1));
          c.cell_y = 8'($urandom_range(0, h - 1));
        end
        push_cmd(c);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
